// ===== hdl/udiv_pkg.sv =====
// ============================================================================
// udiv_pkg
// Shared constants, controller states and command types for the unsigned
// restoring divider.
// ============================================================================
package udiv_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DATA_WIDTH);

    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DATA_WIDTH - 1);

    typedef logic [DATA_WIDTH-1:0] data_t;
    typedef logic [CNT_W-1:0]      cnt_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WRITE
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;   // capture operands, clear partial remainder
        logic step;   // one shift-and-subtract iteration
        logic store;  // move the quotient into the output register
    } cmd_t;

endpackage

// ===== hdl/udiv_if.sv =====
// ============================================================================
// udiv_in_if / udiv_out_if
// Valid/ready channels for operand beats and quotient beats.
// ============================================================================
interface udiv_in_if;

    logic                  valid;
    logic                  ready;
    udiv_pkg::data_t       dividend;
    udiv_pkg::data_t       divisor;

    modport source (output valid, output dividend, output divisor, input ready);
    modport sink   (input valid, input dividend, input divisor, output ready);

endinterface

interface udiv_out_if;

    logic                  valid;
    logic                  ready;
    udiv_pkg::data_t       quotient;

    modport source (output valid, output quotient, input ready);
    modport sink   (input valid, input quotient, output ready);

endinterface

// ===== hdl/udiv_dpath.sv =====
// ============================================================================
// udiv_dpath
// Restoring division datapath: operand, remainder and quotient registers,
// one subtract-and-compare per step, and the output quotient register.
// ============================================================================
module udiv_dpath (
    input  logic               clk,
    input  udiv_pkg::cmd_t     cmd,
    input  udiv_pkg::data_t    dividend,
    input  udiv_pkg::data_t    divisor,
    output udiv_pkg::data_t    quotient
);

    localparam int W = udiv_pkg::DATA_WIDTH;

    udiv_pkg::data_t num_reg, num_next;
    udiv_pkg::data_t den_reg, den_next;
    udiv_pkg::data_t rem_reg, rem_next;
    udiv_pkg::data_t quo_reg, quo_next;
    logic            den_zero_reg, den_zero_next;
    udiv_pkg::data_t out_reg, out_next;

    logic [W:0] rem_shift;
    logic [W:0] diff;
    logic       fits;

    // Remainder stays below the divisor, so the shifted value needs one extra bit
    assign rem_shift = {rem_reg, num_reg[W-1]};
    assign diff      = rem_shift - {1'b0, den_reg};
    // no borrow out of the top bit means the divisor fits
    assign fits      = !diff[W];

    always_comb
    begin
        num_next      = num_reg;
        den_next      = den_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        den_zero_next = den_zero_reg;
        out_next      = out_reg;

        if (cmd.store)
        begin
            out_next = den_zero_reg ? '0 : quo_reg;
        end

        if (cmd.load)
        begin
            num_next      = dividend;
            den_next      = divisor;
            rem_next      = '0;
            quo_next      = '0;
            den_zero_next = (divisor == '0);
        end
        else if (cmd.step)
        begin
            num_next = {num_reg[W-2:0], 1'b0};
            quo_next = {quo_reg[W-2:0], fits};
            rem_next = fits ? diff[W-1:0] : rem_shift[W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg      <= num_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        den_zero_reg <= den_zero_next;
        out_reg      <= out_next;
    end

    assign quotient = out_reg;

endmodule

// ===== hdl/udiv_ctrl.sv =====
// ============================================================================
// udiv_ctrl
// Controller: operand handshake, step counter and output beat valid.
// ============================================================================
module udiv_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output udiv_pkg::cmd_t     cmd
);

    udiv_pkg::state_t state_reg, state_next;
    udiv_pkg::cnt_t   cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            udiv_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = udiv_pkg::ST_RUN;
                end
            end
            udiv_pkg::ST_RUN:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = udiv_pkg::ST_WRITE;
                end
            end
            udiv_pkg::ST_WRITE:
            begin
                if (slot_free)
                begin
                    state_next = in_valid ? udiv_pkg::ST_RUN : udiv_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = udiv_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready  = 1'b0;
        cmd.step  = 1'b0;
        cmd.store = 1'b0;
        unique case (state_reg)
            udiv_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            udiv_pkg::ST_RUN:
            begin
                cmd.step = 1'b1;
            end
            udiv_pkg::ST_WRITE:
            begin
                in_ready  = slot_free;
                cmd.store = slot_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        cmd.load = in_valid && in_ready;
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.load)
        begin
            cnt_next = udiv_pkg::LAST_STEP;
        end
        else if (cmd.step)
        begin
            cnt_next = cnt_reg - udiv_pkg::cnt_t'(1);
        end

        // hold the beat until taken
        if (cmd.store)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= udiv_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_store_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> (!out_valid_reg || out_ready))
        else $error("quotient stored over an untaken beat");

    a_last_step_to_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == udiv_pkg::ST_RUN && cnt_reg == '0) |=>
            (state_reg == udiv_pkg::ST_WRITE))
        else $error("run did not end in write");

    a_no_accept_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == udiv_pkg::ST_RUN) |-> !in_ready)
        else $error("operands accepted mid-division");

    a_load_sets_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == udiv_pkg::ST_RUN && cnt_reg == udiv_pkg::LAST_STEP))
        else $error("load did not start a full run");

endmodule

// ===== hdl/unsigned_restoring_divider.sv =====
// ============================================================================
// unsigned_restoring_divider
// 32-bit unsigned integer divider, restoring shift-and-subtract.
// ============================================================================
// Usage:
//   in_ch  carries one operand beat: dividend and divisor, both unsigned.
//   out_ch carries one quotient beat per operand beat, floor(dividend /
//   divisor), in order. A zero divisor gives a quotient of zero.
// Timing:
//   The shared subtract-and-compare unit produces one quotient bit per
//   cycle in ST_RUN after the operand beat is taken. ST_WRITE follows,
//   storing the quotient in the output register, and the quotient appears
//   on out_ch the cycle after. No new beat is taken during the run;
//   back-to-back operands are taken in the cycle the quotient is written.
// Reset:
//   rst_n clears the controller; no beat is pending and in_ch.ready is high.
// Stall:
//   The output register holds the quotient until taken. A new beat may be
//   accepted and divided meanwhile; the controller then waits with
//   in_ch.ready low until the output register is free.
// ============================================================================
module unsigned_restoring_divider (
    input  logic       clk,
    input  logic       rst_n,
    udiv_in_if.sink    in_ch,
    udiv_out_if.source out_ch
);

    udiv_pkg::cmd_t cmd;

    udiv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd)
    );

    udiv_dpath u_dpath (
        .clk      (clk),
        .cmd      (cmd),
        .dividend (in_ch.dividend),
        .divisor  (in_ch.divisor),
        .quotient (out_ch.quotient)
    );

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: unsigned restoring divider testbench
// Drives operand beats in random bursts, stalls the quotient channel on its
// own pattern, and checks every quotient against a bit-exact shift-subtract
// predictor held in a small scoreboard.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BEATS   = 1050;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 40;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_HOLDOFF
    } rx_pattern_t;

    class quotient_board;
        udiv_pkg::data_t expected_q[$];
        int    errors;
        int    beats_in;
        int    beats_checked;
        int    zero_divisors;
        int    zero_dividends;
        int    wide_divisors;

        function new();
            errors         = 0;
            beats_in       = 0;
            beats_checked  = 0;
            zero_divisors  = 0;
            zero_dividends = 0;
            wide_divisors  = 0;
        endfunction

        // Restoring division with a partial remainder one bit wider than the
        // operands, so divisors with the top bit set still divide exactly.
        function udiv_pkg::data_t floor_quotient(udiv_pkg::data_t num,
                                                 udiv_pkg::data_t den);
            logic [udiv_pkg::DATA_WIDTH:0] partial;
            udiv_pkg::data_t               quo;
            partial = '0;
            quo     = '0;
            if (den == '0 || num == '0)
                return '0;
            for (int k = udiv_pkg::DATA_WIDTH - 1; k >= 0; k--)
            begin
                partial = {partial[udiv_pkg::DATA_WIDTH-1:0], num[k]};
                quo     = {quo[udiv_pkg::DATA_WIDTH-2:0], 1'b0};
                if (partial >= {1'b0, den})
                begin
                    partial = partial - {1'b0, den};
                    quo[0]  = 1'b1;
                end
            end
            return quo;
        endfunction

        function void note_operands(udiv_pkg::data_t num, udiv_pkg::data_t den);
            beats_in++;
            if (den == '0)
                zero_divisors++;
            if (num == '0)
                zero_dividends++;
            if (den[udiv_pkg::DATA_WIDTH-1])
                wide_divisors++;
            expected_q.push_back(floor_quotient(num, den));
        endfunction

        function void check_quotient(udiv_pkg::data_t actual);
            udiv_pkg::data_t want;
            if (expected_q.size() == 0)
            begin
                $error("quotient beat 0x%08h arrived with nothing outstanding", actual);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            beats_checked++;
            if (actual !== want)
            begin
                $error("quotient: expected 0x%08h, actual 0x%08h", want, actual);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    udiv_in_if  in_ch ();
    udiv_out_if out_ch ();

    unsigned_restoring_divider DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    quotient_board board;
    int            idle_cycles;
    int            burst_left;
    rx_pattern_t   rx_pattern;
    int            rx_hold;
    int            rx_cycle;

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.dividend  = '0;
        in_ch.divisor   = '0;
        out_ch.ready    = 1'b0;
        idle_cycles     = 0;
        burst_left      = 0;
        rx_pattern      = RX_OPEN;
        rx_hold         = 0;
        rx_cycle        = 0;
        board           = new();
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Sample both channels before this edge's updates land.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
                board.check_quotient(out_ch.quotient);
            if (in_ch.valid && in_ch.ready)
                board.note_operands(in_ch.dividend, in_ch.divisor);
            if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: patterns drawn at random in turn: free flow, coin flips, or
    // long holds with a single ready cycle in between.
    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 700 == 0)
            rx_pattern <= rx_pattern_t'($urandom_range(2, 0));
        if (rx_hold != 0)
        begin
            out_ch.ready <= 1'b0;
            rx_hold      <= rx_hold - 1;
        end
        else
        begin
            case (rx_pattern)
                RX_OPEN:    out_ch.ready <= 1'b1;
                RX_COIN:    out_ch.ready <= 1'($urandom_range(1, 0));
                default:
                begin
                    out_ch.ready <= 1'b1;
                    rx_hold      <= $urandom_range(60, 5);
                end
            endcase
        end
    end

    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("unsigned_restoring_divider: mismatch");
        $finish;
    end

    // Present one operand beat and hold it until taken; open a new burst with
    // a random gap when the current one runs out.
    task automatic send_operands(udiv_pkg::data_t num, udiv_pkg::data_t den);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(24, 1);
            gap        = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(40, 1);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_ch.valid    <= 1'b1;
        in_ch.dividend <= num;
        in_ch.divisor  <= den;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    // Drop valid and hold off until every outstanding quotient is back.
    task automatic drain_quotients();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    function automatic udiv_pkg::data_t random_width_value();
        int w;
        w = $urandom_range(udiv_pkg::DATA_WIDTH, 1);
        return udiv_pkg::data_t'($urandom() >> (udiv_pkg::DATA_WIDTH - w));
    endfunction

    initial
    begin
        udiv_pkg::data_t num;
        udiv_pkg::data_t den;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: zero operands, extremes, top-bit divisors, near-equal pairs.
        send_operands(32'h0000_0000, 32'h0000_0000);
        send_operands(32'h0000_0000, 32'h0000_0005);
        send_operands(32'h0000_0005, 32'h0000_0000);
        send_operands(32'hFFFF_FFFF, 32'h0000_0000);
        send_operands(32'hFFFF_FFFF, 32'h0000_0001);
        send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_operands(32'hFFFF_FFFF, 32'h8000_0000);
        send_operands(32'hFFFF_FFFF, 32'h8000_0001);
        send_operands(32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_operands(32'h8000_0000, 32'h8000_0001);
        send_operands(32'h8000_0000, 32'h0000_0001);
        send_operands(32'hFFFF_FFFF, 32'h0000_0002);
        send_operands(32'h0000_0001, 32'h0000_0001);
        send_operands(32'h0000_0001, 32'hFFFF_FFFF);
        send_operands(32'h0000_0007, 32'h0000_0007);
        send_operands(32'h0000_0006, 32'h0000_0007);
        send_operands(32'h0000_0064, 32'h0000_0003);
        send_operands(32'h1234_5678, 32'h0000_0001);
        send_operands(32'hAAAA_AAAA, 32'h5555_5555);
        drain_quotients();

        for (int i = 0; i < RANDOM_BEATS; i++)
        begin
            case ($urandom_range(7, 0))
                0:
                begin
                    num = $urandom();
                    den = $urandom();
                end
                1:
                begin
                    num = $urandom();
                    den = random_width_value();
                end
                2:
                begin
                    num = random_width_value();
                    den = random_width_value();
                end
                3:
                begin
                    num = $urandom();
                    den = ($urandom_range(1, 0) == 0) ? '0 : random_width_value();
                    if ($urandom_range(1, 0) == 0)
                        num = '0;
                end
                4:
                begin
                    num = $urandom();
                    den = $urandom() | 32'h8000_0000;
                end
                5:
                begin
                    num = $urandom();
                    den = num + udiv_pkg::data_t'($urandom_range(2, 0)) - 1;
                end
                default:
                begin
                    num = $urandom();
                    den = udiv_pkg::data_t'($urandom_range(255, 1));
                end
            endcase
            send_operands(num, den);
            if (i == RANDOM_BEATS / 2)
                drain_quotients();
        end

        drain_quotients();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Divided %0d operand beats, %0d quotients compared.",
                 board.beats_in, board.beats_checked);
        $display("Zero divisors %0d, zero dividends %0d, divisors with top bit set %0d.",
                 board.zero_divisors, board.zero_dividends, board.wide_divisors);
        if (board.errors == 0 && board.pending() == 0)
            $display("unsigned_restoring_divider: match");
        else
            $display("unsigned_restoring_divider: mismatch");
        $finish;
    end

endmodule
